// ===== rtl/evrg_pkg.sv =====
// Shared types, constants and the arctangent table of the ellipse vertex ring generator.
`default_nettype none
package evrg_pkg;

  localparam int DEF_MAX_SIDES    = 64;
  localparam int DEF_CORDIC_STEPS = 24;
  localparam int SIDES_W          = 7;
  localparam logic [SIDES_W-1:0] RING_SIDES_RESET = 7'd8;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] major_x;
    logic signed [31:0] major_y;
    logic signed [31:0] major_z;
    logic signed [31:0] minor_x;
    logic signed [31:0] minor_y;
    logic signed [31:0] minor_z;
  } item_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic [5:0]         vertex_index;
    logic               last_vertex;
  } vertex_t;

  // One classified ring waiting for the vertex engine.
  typedef struct packed {
    item_t       geom;
    logic [31:0] base_angle;
  } ring_t;

  typedef enum logic [1:0] {F_IDLE, F_VEC, F_OUT} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_DIV, B_ROT, B_MAC, B_EMIT} back_state_t;

  // Arctangent of 2^-i as a binary angle, 2^32 per turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0:  t = 32'h20000000;
      5'd1:  t = 32'h12E4051D;
      5'd2:  t = 32'h09FB385B;
      5'd3:  t = 32'h051111D4;
      5'd4:  t = 32'h028B0D43;
      5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E;
      5'd7:  t = 32'h00517C55;
      5'd8:  t = 32'h0028BE53;
      5'd9:  t = 32'h00145F2E;
      5'd10: t = 32'h000A2F98;
      5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6;
      5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2F9;
      5'd15: t = 32'h0000517C;
      5'd16: t = 32'h000028BE;
      5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A2F;
      5'd19: t = 32'h00000517;
      5'd20: t = 32'h0000028B;
      5'd21: t = 32'h00000145;
      5'd22: t = 32'h000000A2;
      5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000028;
      5'd25: t = 32'h00000014;
      5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005;
      5'd28: t = 32'h00000002;
      5'd29: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/evrg_queue.sv =====
// Two-entry queue used between the front and back parts and on the result side.
`default_nettype none
module evrg_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  logic [W-1:0] mem [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/evrg_front.sv =====
// Front part: takes an ellipse and finds the polar angle of its major axis in the x-z plane.
`default_nettype none
module evrg_front #(
  parameter int CORDIC_STEPS = evrg_pkg::DEF_CORDIC_STEPS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire evrg_pkg::item_t item,
  output logic                 full,
  output logic                 ring_push,
  output evrg_pkg::ring_t      ring,
  input  wire logic            ring_full
);

  localparam int IW = $clog2(CORDIC_STEPS);

  evrg_pkg::front_state_t state, state_next;
  evrg_pkg::item_t        it;
  logic signed [34:0]     x;
  logic signed [34:0]     y;
  logic signed [33:0]     z;
  logic [IW-1:0]          i;
  logic [31:0]            angle;
  logic                   accept;
  logic                   last_step;
  logic signed [34:0]     ax;
  logic signed [34:0]     az;
  logic [31:0]            t_next;
  logic signed [33:0]     z_next;
  logic signed [33:0]     tt;

  assign full      = (state != evrg_pkg::F_IDLE);
  assign accept    = push && (state == evrg_pkg::F_IDLE);
  assign last_step = (i == IW'(CORDIC_STEPS - 1));
  assign ax = item.major_x[31] ? -35'(item.major_x) : 35'(item.major_x);
  assign az = item.major_z[31] ? -35'(item.major_z) : 35'(item.major_z);
  assign tt = {2'b00, evrg_pkg::atan_turn(5'(i))};
  assign z_next = (y > 0) ? z + tt : z - tt;
  assign t_next = z_next[31:0];

  assign ring_push       = (state == evrg_pkg::F_OUT);
  assign ring.geom       = it;
  assign ring.base_angle = 32'd0 - angle;

  always_comb begin
    state_next = state;
    case (state)
      evrg_pkg::F_IDLE: begin
        if (accept) begin
          if (item.major_x == 32'sd0 || item.major_z == 32'sd0) begin
            state_next = evrg_pkg::F_OUT;
          end else begin
            state_next = evrg_pkg::F_VEC;
          end
        end
      end
      evrg_pkg::F_VEC: begin
        if (last_step) begin
          state_next = evrg_pkg::F_OUT;
        end
      end
      evrg_pkg::F_OUT: begin
        if (!ring_full) begin
          state_next = evrg_pkg::F_IDLE;
        end
      end
      default: state_next = evrg_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= evrg_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it <= item;
      x  <= ax;
      y  <= az;
      z  <= 34'sd0;
      i  <= '0;
      // On-axis and zero cases are settled here without the CORDIC.
      if (item.major_z == 32'sd0) begin
        angle <= (item.major_x < 0) ? 32'h80000000 : 32'h00000000;
      end else if (item.major_x == 32'sd0) begin
        angle <= (item.major_z > 0) ? 32'h40000000 : 32'hC0000000;
      end
    end else if (state == evrg_pkg::F_VEC) begin
      if (y > 0) begin
        x <= x + (y >>> i);
        y <= y - (x >>> i);
      end else begin
        x <= x - (y >>> i);
        y <= y + (x >>> i);
      end
      z <= z_next;
      i <= i + 1'b1;
      if (last_step) begin
        if (it.major_x > 0 && it.major_z > 0) begin
          angle <= t_next;
        end else if (it.major_x < 0 && it.major_z > 0) begin
          angle <= 32'h80000000 - t_next;
        end else if (it.major_x < 0) begin
          angle <= 32'h80000000 + t_next;
        end else begin
          angle <= 32'd0 - t_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/evrg_back.sv =====
// Back part: steps around the ring, runs sine and cosine, and forms each saturated vertex.
`default_nettype none
module evrg_back #(
  parameter int MAX_SIDES    = evrg_pkg::DEF_MAX_SIDES,
  parameter int CORDIC_STEPS = evrg_pkg::DEF_CORDIC_STEPS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [evrg_pkg::SIDES_W-1:0] ring_sides,
  input  wire evrg_pkg::ring_t              ring,
  input  wire logic                         ring_empty,
  output logic                              ring_pop,
  output logic                              vtx_push,
  output evrg_pkg::vertex_t                 vtx,
  input  wire logic                         vtx_full
);

  localparam int IW = $clog2(CORDIC_STEPS);
  localparam int SW = evrg_pkg::SIDES_W;

  evrg_pkg::back_state_t state, state_next;
  evrg_pkg::ring_t       e;
  logic [SW-1:0]         n;
  logic [SW-1:0]         n_clamp;
  logic [5:0]            dcnt;
  logic [SW-1:0]         drem;
  logic [31:0]           qstep;
  logic [SW-1:0]         rstep;
  logic [SW:0]           dtry;
  logic [31:0]           off;
  logic [31:0]           off_next;
  logic [SW:0]           racc;
  logic [SW:0]           racc_sum;
  logic [SW:0]           racc_next;
  logic [SW-1:0]         k;
  logic                  last_k;
  logic signed [33:0]    cx;
  logic signed [33:0]    cy;
  logic signed [33:0]    cz;
  logic [IW-1:0]         i;
  logic                  last_step;
  logic                  flip;
  logic [31:0]           a;
  logic [31:0]           r;
  logic [31:0]           a_next;
  logic [31:0]           r_next;
  logic signed [33:0]    tt;
  logic [1:0]            cj;
  logic [1:0]            ph;
  logic signed [31:0]    sel_ctr;
  logic signed [31:0]    sel_maj;
  logic signed [31:0]    sel_mnr;
  logic signed [65:0]    prod;
  logic signed [65:0]    acc;
  logic signed [65:0]    sum;
  logic signed [35:0]    rnd;
  logic signed [31:0]    sat;
  logic signed [31:0]    res [3];

  always_comb begin
    if (ring_sides < SW'(2)) begin
      n_clamp = SW'(2);
    end else if (ring_sides > SW'(MAX_SIDES)) begin
      n_clamp = SW'(MAX_SIDES);
    end else begin
      n_clamp = ring_sides;
    end
  end

  assign dtry      = {drem, (dcnt == 6'd32)};
  assign last_step = (i == IW'(CORDIC_STEPS - 1));
  assign last_k    = (k + 1'b1 == n);
  assign racc_sum  = racc + {1'b0, rstep};
  assign a         = e.base_angle - off;
  assign flip      = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
  assign r         = flip ? a - 32'h80000000 : a;
  assign tt        = {2'b00, evrg_pkg::atan_turn(5'(i))};
  assign ring_pop  = (state == evrg_pkg::B_IDLE) && !ring_empty;
  assign vtx_push  = (state == evrg_pkg::B_EMIT);

  // Offset of the following vertex: the whole step plus one whenever the
  // accumulated remainder reaches the side count.
  always_comb begin
    if (racc_sum >= {1'b0, n}) begin
      racc_next = racc_sum - {1'b0, n};
      off_next  = off + qstep + 32'd1;
    end else begin
      racc_next = racc_sum;
      off_next  = off + qstep;
    end
  end

  assign a_next = e.base_angle - off_next;
  assign r_next = ((a_next[31:30] == 2'b01) || (a_next[31:30] == 2'b10)) ?
                  a_next - 32'h80000000 : a_next;

  always_comb begin
    case (cj)
      2'd0: begin
        sel_ctr = e.geom.center_x;
        sel_maj = e.geom.major_x;
        sel_mnr = e.geom.minor_x;
      end
      2'd1: begin
        sel_ctr = e.geom.center_y;
        sel_maj = e.geom.major_y;
        sel_mnr = e.geom.minor_y;
      end
      default: begin
        sel_ctr = e.geom.center_z;
        sel_maj = e.geom.major_z;
        sel_mnr = e.geom.minor_z;
      end
    endcase
  end

  assign sum = acc + prod;
  assign rnd = 36'((sum + 66'sd536870912) >>> 30);
  always_comb begin
    if (rnd > 36'sd2147483647) begin
      sat = 32'sh7FFFFFFF;
    end else if (rnd < -36'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = rnd[31:0];
    end
  end

  assign vtx.vertex_x     = res[0];
  assign vtx.vertex_y     = res[1];
  assign vtx.vertex_z     = res[2];
  assign vtx.vertex_index = k[5:0];
  assign vtx.last_vertex  = last_k;

  always_comb begin
    state_next = state;
    case (state)
      evrg_pkg::B_IDLE: begin
        if (!ring_empty) begin
          state_next = evrg_pkg::B_DIV;
        end
      end
      evrg_pkg::B_DIV: begin
        if (dcnt == 6'd0) begin
          state_next = evrg_pkg::B_ROT;
        end
      end
      evrg_pkg::B_ROT: begin
        if (last_step) begin
          state_next = evrg_pkg::B_MAC;
        end
      end
      evrg_pkg::B_MAC: begin
        if (ph == 2'd2 && cj == 2'd2) begin
          state_next = evrg_pkg::B_EMIT;
        end
      end
      evrg_pkg::B_EMIT: begin
        if (!vtx_full) begin
          state_next = last_k ? evrg_pkg::B_IDLE : evrg_pkg::B_ROT;
        end
      end
      default: state_next = evrg_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= evrg_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      evrg_pkg::B_IDLE: begin
        e     <= ring;
        n     <= n_clamp;
        dcnt  <= 6'd32;
        drem  <= '0;
        qstep <= '0;
        off   <= '0;
        racc  <= '0;
        k     <= '0;
        i     <= '0;
      end
      evrg_pkg::B_DIV: begin
        // Restoring division of one turn by the side count, one bit a cycle.
        if (dtry >= {1'b0, n}) begin
          drem  <= SW'(dtry - {1'b0, n});
          qstep <= {qstep[30:0], 1'b1};
        end else begin
          drem  <= dtry[SW-1:0];
          qstep <= {qstep[30:0], 1'b0};
        end
        dcnt <= dcnt - 1'b1;
        if (dcnt == 6'd0) begin
          rstep <= (dtry >= {1'b0, n}) ? SW'(dtry - {1'b0, n}) : dtry[SW-1:0];
        end
        cx <= evrg_pkg::CORDIC_GAIN;
        cy <= 34'sd0;
        cz <= {{2{r[31]}}, r};
        i  <= '0;
      end
      evrg_pkg::B_ROT: begin
        if (cz >= 0) begin
          cx <= cx - (cy >>> i);
          cy <= cy + (cx >>> i);
          cz <= cz - tt;
        end else begin
          cx <= cx + (cy >>> i);
          cy <= cy - (cx >>> i);
          cz <= cz + tt;
        end
        i <= i + 1'b1;
        if (last_step) begin
          cj <= 2'd0;
          ph <= 2'd0;
        end
      end
      evrg_pkg::B_MAC: begin
        case (ph)
          2'd0: begin
            prod <= $signed(flip ? -cx : cx) * $signed(sel_maj);
            ph   <= 2'd1;
          end
          2'd1: begin
            acc  <= {{4{sel_ctr[31]}}, sel_ctr, 30'd0} + prod;
            prod <= $signed(flip ? -cy : cy) * $signed(sel_mnr);
            ph   <= 2'd2;
          end
          default: begin
            res[cj] <= sat;
            cj      <= cj + 1'b1;
            ph      <= 2'd0;
          end
        endcase
      end
      evrg_pkg::B_EMIT: begin
        if (!vtx_full) begin
          // The next rotation starts from the folded angle of the next vertex.
          k    <= k + 1'b1;
          racc <= racc_next;
          off  <= off_next;
          cx   <= evrg_pkg::CORDIC_GAIN;
          cy   <= 34'sd0;
          cz   <= {{2{r_next[31]}}, r_next};
          i    <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/ellipse_vertex_ring_generator.sv =====
// Top level of the ellipse vertex ring generator: configuration register, front, queues, back.
//
//  channel   direction  handshake            beat
//  item      in         push / full          one ellipse (center, major, minor)
//  vertex    out        pop / empty          one ring vertex with index and last flag
//  config    in         APB psel/penable     ring_sides register at byte address 0
//
// The front finds the polar angle of an ellipse, with its vectoring CORDIC off the axes.
// The back takes a ring and divides one turn by the side count, then for each
// vertex runs the rotation CORDIC loop, uses one multiplier six times and
// emits the vertex.
// Reset (rst, synchronous) empties both queues and sets ring_sides to 8.
// A full result queue stalls the back; the front keeps classifying until the ring queue is full.
`default_nettype none
module ellipse_vertex_ring_generator #(
  parameter int MAX_SIDES    = evrg_pkg::DEF_MAX_SIDES,
  parameter int CORDIC_STEPS = evrg_pkg::DEF_CORDIC_STEPS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire evrg_pkg::item_t   item,
  output logic                   full,
  input  wire logic              pop,
  output evrg_pkg::vertex_t      vertex,
  output logic                   empty,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [1:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [evrg_pkg::SIDES_W-1:0] ring_sides;
  evrg_pkg::ring_t              ring_in;
  evrg_pkg::ring_t              ring_out;
  logic                         ring_push;
  logic                         ring_full;
  logic                         ring_pop;
  logic                         ring_empty;
  evrg_pkg::vertex_t            vtx;
  logic                         vtx_push;
  logic                         vtx_full;

  // The single register fills the whole 4-byte word at address 0.
  assign pready = 1'b1;
  assign prdata = {25'd0, ring_sides} | {30'd0, paddr & 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_sides <= evrg_pkg::RING_SIDES_RESET;
    end else if (psel && penable && pwrite && pready) begin
      ring_sides <= pwdata[evrg_pkg::SIDES_W-1:0];
    end
  end

  evrg_front #(.CORDIC_STEPS(CORDIC_STEPS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .ring_push (ring_push),
    .ring      (ring_in),
    .ring_full (ring_full)
  );

  evrg_queue #(.W($bits(evrg_pkg::ring_t))) u_ring_q (
    .clk   (clk),
    .rst   (rst),
    .push  (ring_push),
    .wdata (ring_in),
    .full  (ring_full),
    .pop   (ring_pop),
    .rdata (ring_out),
    .empty (ring_empty)
  );

  evrg_back #(.MAX_SIDES(MAX_SIDES), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .ring_sides (ring_sides),
    .ring       (ring_out),
    .ring_empty (ring_empty),
    .ring_pop   (ring_pop),
    .vtx_push   (vtx_push),
    .vtx        (vtx),
    .vtx_full   (vtx_full)
  );

  evrg_queue #(.W($bits(evrg_pkg::vertex_t))) u_vtx_q (
    .clk   (clk),
    .rst   (rst),
    .push  (vtx_push),
    .wdata (vtx),
    .full  (vtx_full),
    .pop   (pop),
    .rdata (vertex),
    .empty (empty)
  );

`ifndef SYNTH
  a_ring_waits: assert property (@(posedge clk) disable iff (rst)
    ring_push && ring_full |=> ring_push && $stable(ring_in))
    else $error("ring changed while stalled");

  a_vtx_push_waits: assert property (@(posedge clk) disable iff (rst)
    vtx_push && vtx_full |=> $stable(vtx)) else $error("vertex changed while stalled");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> empty) else $error("result queue not empty after reset");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the ellipse vertex ring generator.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  // The block is slow on large rings, so the watchdog
  // counts idle cycles with margin for a full ring behind a long receiver stall.
  localparam int STALL_LIMIT = 40000;
  localparam int TAIL_CYCLES = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  evrg_pkg::item_t item = '0;
  logic full;
  logic pop = 1'b0;
  evrg_pkg::vertex_t vertex;
  logic empty;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ellipse_vertex_ring_generator dut (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full),
    .pop(pop), .vertex(vertex), .empty(empty),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Ellipses waiting to be offered, and vertices the block still owes us.
  evrg_pkg::item_t ellipse_queue[$];
  evrg_pkg::vertex_t vertex_queue[$];
  logic [6:0] sides_reg = evrg_pkg::RING_SIDES_RESET;
  int errors = 0;
  int idle_cycles = 0;
  bit pop_hold = 1'b0;
  bit calm = 1'b0;       // a stretch with no idling on either side
  bit stimulus_done = 1'b0;

  task automatic report(input string what, input evrg_pkg::vertex_t got,
                        input evrg_pkg::vertex_t want);
    $display("[%0t] vertex %s: got %h want %h", $time, what, got, want);
    errors++;
  endtask

  function automatic longint signed asr(input longint signed v, input int s);
    return v >>> s;
  endfunction

  // First-quadrant vectoring CORDIC on non-negative x, y.
  function automatic logic [31:0] quadrant_angle(input longint signed x,
                                                 input longint signed y);
    longint signed z, dx, dy;
    int n;
    z = 0;
    n = (evrg_pkg::DEF_CORDIC_STEPS > 32) ? 32 : evrg_pkg::DEF_CORDIC_STEPS;
    for (int i = 0; i < n; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(evrg_pkg::atan_turn(5'(i)));
      end else begin
        x -= dx; y += dy; z -= longint'(evrg_pkg::atan_turn(5'(i)));
      end
    end
    return z[31:0];
  endfunction

  function automatic logic [31:0] heading(input longint signed x, input longint signed z);
    logic [31:0] t;
    if (x == 0 && z == 0) return 32'h0;
    if (z == 0) return (x > 0) ? 32'h0 : 32'h8000_0000;
    if (x == 0) return (z > 0) ? 32'h4000_0000 : 32'hC000_0000;
    t = quadrant_angle(x < 0 ? -x : x, z < 0 ? -z : z);
    if (x > 0 && z > 0) return t;
    if (x < 0 && z > 0) return 32'h8000_0000 - t;
    if (x < 0) return 32'h8000_0000 + t;
    return 32'h0 - t;
  endfunction

  // Rotation CORDIC in Q2.30; second and third quadrants are folded by half a turn.
  task automatic sin_cos(input logic [31:0] a, output longint signed c,
                         output longint signed s);
    bit flip;
    logic [31:0] r;
    longint signed x, y, z, dx, dy;
    int n;
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    r = flip ? a - 32'h8000_0000 : a;
    z = longint'(signed'(r));
    x = longint'(evrg_pkg::CORDIC_GAIN);
    y = 0;
    n = (evrg_pkg::DEF_CORDIC_STEPS > 32) ? 32 : evrg_pkg::DEF_CORDIC_STEPS;
    for (int i = 0; i < n; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(evrg_pkg::atan_turn(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(evrg_pkg::atan_turn(5'(i)));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [31:0] place(input logic signed [31:0] ctr,
      input logic signed [31:0] maj, input logic signed [31:0] mnr,
      input longint signed c, input longint signed s);
    longint signed acc, v;
    acc = longint'(ctr) * 64'sd1073741824 + c * longint'(maj) + s * longint'(mnr);
    v = (acc + 64'sd536870912) >>> 30;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Appends the ring of vertices that one accepted ellipse produces.
  task automatic predict_ring(input evrg_pkg::item_t e);
    int n;
    logic [31:0] base, off;
    longint signed c, s;
    evrg_pkg::vertex_t v;
    n = sides_reg;
    if (n < 2) n = 2;
    if (n > evrg_pkg::DEF_MAX_SIDES) n = evrg_pkg::DEF_MAX_SIDES;
    base = 32'h0 - heading(longint'(e.major_x), longint'(e.major_z));
    for (int k = 0; k < n; k++) begin
      off = 32'((64'(k) << 32) / 64'(n));
      sin_cos(base - off, c, s);
      v.vertex_x = place(e.center_x, e.major_x, e.minor_x, c, s);
      v.vertex_y = place(e.center_y, e.major_y, e.minor_y, c, s);
      v.vertex_z = place(e.center_z, e.major_z, e.minor_z, c, s);
      v.vertex_index = 6'(k);
      v.last_vertex = (k + 1 == n);
      vertex_queue.push_back(v);
    end
  endtask

  // Driver: offers the head of the queue at random, keeping it at the head until accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        predict_ring(item);
        void'(ellipse_queue.pop_front());
      end
      if (ellipse_queue.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
        item <= ellipse_queue[0];
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: pops at random and checks each beat against the oldest prediction.
  always @(posedge clk) begin
    evrg_pkg::vertex_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (vertex_queue.size() == 0) begin
          report("unexpected", vertex, '0);
        end else begin
          want = vertex_queue.pop_front();
          if (vertex.vertex_x !== want.vertex_x) report("x", vertex, want);
          if (vertex.vertex_y !== want.vertex_y) report("y", vertex, want);
          if (vertex.vertex_z !== want.vertex_z) report("z", vertex, want);
          if (vertex.vertex_index !== want.vertex_index) report("index", vertex, want);
          if (vertex.last_vertex !== want.last_vertex) report("last", vertex, want);
        end
      end
      pop <= !pop_hold && (calm || $urandom_range(99) >= 29);
    end
  end

  // Watchdog: a long run of cycles with no beat on either side is a hang.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst || pop_hold) idle_cycles <= 0;
    else if (!stimulus_done || vertex_queue.size() > 0) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("ellipse_vertex_ring_generator: mismatch");
      $finish;
    end
  end

  function automatic logic [31:0] any_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return $urandom_range(131071) - 65536;  // small, about +-1.0
      default: return $urandom;
    endcase
  endfunction

  function automatic evrg_pkg::item_t random_ellipse();
    evrg_pkg::item_t e;
    e.center_x = any_word(); e.center_y = any_word(); e.center_z = any_word();
    e.major_x = any_word(); e.major_y = any_word(); e.major_z = any_word();
    e.minor_x = any_word(); e.minor_y = any_word(); e.minor_z = any_word();
    return e;
  endfunction

  function automatic evrg_pkg::item_t shaped(input logic [31:0] mx, input logic [31:0] mz);
    evrg_pkg::item_t e;
    e = '0;
    e.center_x = 32'h0001_0000; e.center_y = 32'hFFFE_0000; e.center_z = 32'h0003_0000;
    e.major_x = mx; e.major_z = mz; e.major_y = 32'h0000_8000;
    e.minor_y = 32'h0002_0000; e.minor_x = 32'h0000_4000;
    return e;
  endfunction

  task automatic wait_drained();
    while (ellipse_queue.size() > 0 || push || vertex_queue.size() > 0) @(posedge clk);
    // Any extra vertex the block might still emit shows up in this tail.
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle then access cycle; pready is always high.
  task automatic write_sides(input logic [6:0] value);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sides_reg = value;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [6:0] settings[5] = '{7'd0, 7'd64, 7'd127, 7'd2, 7'd13};
    evrg_pkg::item_t e;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: axis cases, all four quadrants, zero major and extreme words,
    // under the reset side count of eight.
    ellipse_queue.push_back(shaped(32'h0001_0000, 32'h0));
    ellipse_queue.push_back(shaped(32'hFFFF_0000, 32'h0));
    ellipse_queue.push_back(shaped(32'h0, 32'h0002_0000));
    ellipse_queue.push_back(shaped(32'h0, 32'hFFFE_0000));
    ellipse_queue.push_back(shaped(32'h0, 32'h0));
    ellipse_queue.push_back(shaped(32'h0003_0000, 32'h0001_0000));
    ellipse_queue.push_back(shaped(32'hFFFD_0000, 32'h0001_0000));
    ellipse_queue.push_back(shaped(32'hFFFD_0000, 32'hFFFF_0000));
    ellipse_queue.push_back(shaped(32'h0003_0000, 32'hFFFF_0000));
    e = '1; ellipse_queue.push_back(e);
    e = {9{32'h8000_0000}}; ellipse_queue.push_back(e);
    e = {9{32'h7FFF_FFFF}}; ellipse_queue.push_back(e);
    e = {9{32'h8000_0000}}; e.major_x = 32'h7FFF_FFFF; ellipse_queue.push_back(e);
    wait_drained();

    // Random phases over several side counts, extremes and out-of-range ones
    // among them. Large rings are slow, so most items use small counts.
    foreach (settings[p]) begin
      write_sides(settings[p]);
      for (int i = 0; i < ((settings[p] >= 64) ? 25 : 115); i++)
        ellipse_queue.push_back(random_ellipse());
      if (p == 3) begin
        // Hold the receiver off long enough for the block to fill and push back.
        pop_hold = 1'b1;
        repeat (3000) @(posedge clk);
        pop_hold = 1'b0;
      end
      if (p == 4) begin
        calm = 1'b1;
        repeat (2000) @(posedge clk);
        calm = 1'b0;
      end
      wait_drained();
    end

    stimulus_done = 1'b1;
    if (errors == 0) $display("ellipse_vertex_ring_generator: match");
    else $display("ellipse_vertex_ring_generator: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
